@@ rtl/lik_pkg.sv @@
// ----------------------------------------------------------------------------
// lik_pkg: shared types and constants for the leg inverse kinematics block
// Widths of the fixed point datapath, register codes and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package lik_pkg;

  // defaults for the top level parameters
  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 18;

  // angle accumulator fraction bits and pi in that scale
  localparam int ANG_BITS = 30;
  localparam int AW       = 34;
  localparam int HW       = 35;
  localparam logic signed [AW-1:0] PI_Q30 = 34'sd3373259426;

  // lengths and squares
  localparam int LEN_W = 17;
  localparam int POS_W = 18;
  localparam int SQ_W  = 36;

  // digit-by-digit square root
  localparam int ROOT_W = 30;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;

  // rotation datapath width
  localparam int CW = 48;

  // register codes (decoded from paddr bit 2)
  localparam logic REG_ABDUCTION = 1'b0;
  localparam logic REG_LINK      = 1'b1;

  // sideband that travels next to the arithmetic
  typedef struct packed {
    logic                    vld;
    logic [1:0]              leg;
    logic                    unr;
    logic                    yneg;
    logic                    ypos;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] z;
    logic [POS_W-1:0]        ay;
  } lik_side_t;

  // atan(2^-i) in 2^-30 rad, rounded to nearest
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      10: v = 32'd1048576;
      11: v = 32'd524288;
      12: v = 32'd262144;
      13: v = 32'd131072;
      14: v = 32'd65536;
      15: v = 32'd32768;
      16: v = 32'd16384;
      17: v = 32'd8192;
      18: v = 32'd4096;
      19: v = 32'd2048;
      20: v = 32'd1024;
      21: v = 32'd512;
      22: v = 32'd256;
      23: v = 32'd128;
      24: v = 32'd64;
      25: v = 32'd32;
      26: v = 32'd16;
      27: v = 32'd8;
      28: v = 32'd4;
      29: v = 32'd2;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lik_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// lik_sqrt_cell: one step of a restoring square root
// Takes the next two radicand bits, decides one root bit, passes on.
// ----------------------------------------------------------------------------
`default_nettype none

module lik_sqrt_cell (
  input  wire                             clk,
  input  wire                             en,
  input  wire  [lik_pkg::RAD_W-1:0]       rad_i,
  input  wire  [lik_pkg::REM_W-1:0]       rem_i,
  input  wire  [lik_pkg::ROOT_W-1:0]      q_i,
  output logic [lik_pkg::RAD_W-1:0]       rad_r,
  output logic [lik_pkg::REM_W-1:0]       rem_r,
  output logic [lik_pkg::ROOT_W-1:0]      q_r
);

  logic [lik_pkg::REM_W+1:0]  rem4;
  logic [lik_pkg::REM_W+1:0]  trial;
  logic [lik_pkg::REM_W+1:0]  diff;
  logic [lik_pkg::RAD_W-1:0]  rad_nxt;
  logic [lik_pkg::REM_W-1:0]  rem_nxt;
  logic [lik_pkg::ROOT_W-1:0] q_nxt;

  // trial subtract of 4q+1
  always_comb begin
    rem4    = {rem_i, rad_i[lik_pkg::RAD_W-1 -: 2]};
    trial   = (lik_pkg::REM_W+2)'({q_i, 2'b01});
    diff    = rem4 - trial;
    rad_nxt = {rad_i[lik_pkg::RAD_W-3:0], 2'b00};
    if (rem4 >= trial) begin
      rem_nxt = diff[lik_pkg::REM_W-1:0];
      q_nxt   = {q_i[lik_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem4[lik_pkg::REM_W-1:0];
      q_nxt   = {q_i[lik_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= rad_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lik_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// lik_cordic_cell: one vectoring rotation of the arctangent chain
// Rotates toward the x axis by atan(2^-IDX) and books the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module lik_cordic_cell #(
  parameter int IDX = 0
) (
  input  wire                                clk,
  input  wire                                en,
  input  wire  signed [lik_pkg::CW-1:0]      cx_i,
  input  wire  signed [lik_pkg::CW-1:0]      cy_i,
  input  wire  signed [lik_pkg::AW-1:0]      ang_i,
  output logic signed [lik_pkg::CW-1:0]      cx_r,
  output logic signed [lik_pkg::CW-1:0]      cy_r,
  output logic signed [lik_pkg::AW-1:0]      ang_r
);

  localparam logic signed [lik_pkg::AW-1:0] STEP =
    lik_pkg::AW'(lik_pkg::atan_q30(IDX));

  logic signed [lik_pkg::CW-1:0] dx, dy, cx_nxt, cy_nxt;
  logic signed [lik_pkg::AW-1:0] ang_nxt;
  logic                          up;

  // direction from the sign of y, zero rotates the other way
  always_comb begin
    dx = cy_i >>> IDX;
    dy = cx_i >>> IDX;
    up = !cy_i[lik_pkg::CW-1] && (cy_i != '0);
    if (up) begin
      cx_nxt  = cx_i + dx;
      cy_nxt  = cy_i - dy;
      ang_nxt = ang_i + STEP;
    end else begin
      cx_nxt  = cx_i - dx;
      cy_nxt  = cy_i + dy;
      ang_nxt = ang_i - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      ang_r <= ang_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/leg_inverse_kinematics.sv @@
// ----------------------------------------------------------------------------
// leg_inverse_kinematics: joint angles of a three-joint quadruped leg
// Foot position in, hip, thigh and knee angles out, one request per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  carries a foot request: tuser = leg, tdata = x, y, z (18 bit each).
//   out_* carries the result: tuser = leg_out, unreachable; tdata = hip,
//   thigh, knee angles in 2^-FRAC_BITS rad.
//   cfg_* is an APB-style port: abduction offset at 0x0, link length at 0x4.
//   Throughput is one request per cycle while the receiver takes results. The
//   pipeline holds the squaring and subtraction registers, thirty square
//   root cells, one rotation cell per CORDIC stage, a combine stage and
//   the output register.
//   Unreachable targets come out with all angles zero and the flag set.
//   Reset empties the pipeline and loads the default lengths; there is no
//   clearing pass. When the receiver stalls the whole pipeline holds and
//   in_tready drops until the waiting result is taken.
//   Lengths must be written only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module leg_inverse_kinematics #(
  parameter int FRAC_BITS     = lik_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = lik_pkg::CORDIC_STAGES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // tuser: leg[1:0]
  input  wire  [1:0]  in_tuser,
  // tdata: foot_x[17:0], foot_y[35:18], foot_z[53:36], zero fill
  input  wire  [55:0] in_tdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  // tuser: leg_out[1:0], unreachable[2]
  output logic [2:0]  out_tuser,
  // tdata: hip_angle[19:0], thigh_angle[39:20], knee_angle[58:40], zero fill
  output logic [63:0] out_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int N   = CORDIC_STAGES;
  localparam int SH  = lik_pkg::ANG_BITS - FRAC_BITS;
  localparam int NR  = lik_pkg::ROOT_W;
  localparam int CW  = lik_pkg::CW;
  localparam int AW  = lik_pkg::AW;
  localparam int HW  = lik_pkg::HW;
  localparam int SQW = lik_pkg::SQ_W;
  localparam int PW  = lik_pkg::POS_W;

  logic en;

  // ---------------- configuration registers ----------------
  logic [lik_pkg::LEN_W-1:0] abd_r, link_r;
  logic [SQW-1:0]            a2_r, lim_r;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abd_r  <= lik_pkg::LEN_W'(6554);
      link_r <= lik_pkg::LEN_W'(13107);
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        lik_pkg::REG_ABDUCTION: abd_r  <= cfg_pwdata[lik_pkg::LEN_W-1:0];
        lik_pkg::REG_LINK:      link_r <= cfg_pwdata[lik_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // squared lengths follow the registers
  always_ff @(posedge clk) begin
    a2_r  <= SQW'(abd_r) * SQW'(abd_r);
    lim_r <= (SQW'(link_r) * SQW'(link_r)) << 2;
  end

  always_comb begin
    case (cfg_paddr[2])
      lik_pkg::REG_ABDUCTION: cfg_prdata = 32'(abd_r);
      lik_pkg::REG_LINK:      cfg_prdata = 32'(link_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- front stages: squares and differences ----------------
  lik_pkg::lik_side_t       sb1_r, sb2_r, sb3_r, sb4_r, sb5_r, sb6_r;
  logic signed [PW-1:0]     y1_r;
  logic [SQW-1:0]           sy2_r, sz2_r, sx2_r, sx3_r, sx4_r;
  logic [SQW-1:0]           side_r, red4_r, red5_r, red6_r, reach5_r, reach6_r;
  logic [SQW-1:0]           hrad_r;
  lik_pkg::lik_side_t       sb1_nxt, sb2_nxt, sb4_nxt, sb6_nxt;
  logic signed [2*PW-1:0]   py, pz, px;

  always_comb begin
    sb1_nxt      = '0;
    sb1_nxt.vld  = in_tvalid;
    sb1_nxt.leg  = in_tuser;
    sb1_nxt.x    = in_tdata[17:0];
    sb1_nxt.z    = in_tdata[53:36];
    sb2_nxt      = sb1_r;
    sb2_nxt.yneg = y1_r[PW-1];
    sb2_nxt.ypos = !y1_r[PW-1] && (y1_r != '0);
    sb2_nxt.ay   = y1_r[PW-1] ? PW'(-y1_r) : PW'(y1_r);
    py           = y1_r * y1_r;
    pz           = sb1_r.z * sb1_r.z;
    px           = sb1_r.x * sb1_r.x;
    // too close to the hip
    sb4_nxt      = sb3_r;
    sb4_nxt.unr  = (side_r <= a2_r);
    // beyond the reach
    sb6_nxt      = sb5_r;
    sb6_nxt.unr  = sb5_r.unr || (reach5_r > lim_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb1_r <= '0;
      sb2_r <= '0;
      sb3_r <= '0;
      sb4_r <= '0;
      sb5_r <= '0;
      sb6_r <= '0;
    end else if (en) begin
      sb1_r <= sb1_nxt;
      sb2_r <= sb2_nxt;
      sb3_r <= sb2_r;
      sb4_r <= sb4_nxt;
      sb5_r <= sb4_r;
      sb6_r <= sb6_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y1_r     <= in_tdata[35:18];
      sy2_r    <= SQW'(py);
      sz2_r    <= SQW'(pz);
      sx2_r    <= SQW'(px);
      side_r   <= sy2_r + sz2_r;
      sx3_r    <= sx2_r;
      red4_r   <= side_r - a2_r;
      sx4_r    <= sx3_r;
      red5_r   <= red4_r;
      reach5_r <= red4_r + sx4_r;
      red6_r   <= red5_r;
      reach6_r <= reach5_r;
      hrad_r   <= lim_r - reach5_r;
    end
  end

  // ---------------- square root chain ----------------
  logic [lik_pkg::RAD_W-1:0]  sq_rad [3][NR+1];
  logic [lik_pkg::REM_W-1:0]  sq_rem [3][NR+1];
  logic [lik_pkg::ROOT_W-1:0] sq_q   [3][NR+1];
  lik_pkg::lik_side_t         sb_sq  [NR+1];

  always_comb begin
    sq_rad[0][0] = {red6_r, 24'd0};
    sq_rad[1][0] = {reach6_r, 24'd0};
    sq_rad[2][0] = {hrad_r, 24'd0};
    sq_rem[0][0] = '0;
    sq_rem[1][0] = '0;
    sq_rem[2][0] = '0;
    sq_q[0][0]   = '0;
    sq_q[1][0]   = '0;
    sq_q[2][0]   = '0;
    sb_sq[0]     = sb6_r;
  end

  for (genvar k = 0; k < NR; k++) begin : g_sq
    for (genvar u = 0; u < 3; u++) begin : g_unit
      lik_sqrt_cell u_cell (
        .clk   (clk),
        .en    (en),
        .rad_i (sq_rad[u][k]),
        .rem_i (sq_rem[u][k]),
        .q_i   (sq_q[u][k]),
        .rad_r (sq_rad[u][k+1]),
        .rem_r (sq_rem[u][k+1]),
        .q_r   (sq_q[u][k+1])
      );
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sb_sq[k+1] <= '0;
      end else if (en) begin
        sb_sq[k+1] <= sb_sq[k];
      end
    end
  end

  // ---------------- arctangent chains: base, tilt, bend, forward ----------------
  logic signed [CW-1:0] co_x   [4][N+1];
  logic signed [CW-1:0] co_y   [4][N+1];
  logic signed [AW-1:0] co_ang [4][N+1];
  lik_pkg::lik_side_t   sb_co  [N+1];
  logic [NR-1:0]        r1, r2, hh;

  always_comb begin
    r1 = sq_q[0][NR];
    r2 = sq_q[1][NR];
    hh = sq_q[2][NR];
    co_y[0][0] = CW'({r1, 12'd0});
    co_x[0][0] = CW'({abd_r, 24'd0});
    co_y[1][0] = CW'({{(CW-PW-24){sb_sq[NR].z[PW-1]}}, sb_sq[NR].z, 24'd0});
    co_x[1][0] = CW'({sb_sq[NR].ay, 24'd0});
    co_y[2][0] = CW'({hh, 12'd0});
    co_x[2][0] = CW'({r2, 12'd0});
    co_y[3][0] = CW'({{(CW-PW-24){sb_sq[NR].x[PW-1]}}, sb_sq[NR].x, 24'd0});
    co_x[3][0] = CW'({r1, 12'd0});
    co_ang[0][0] = '0;
    co_ang[1][0] = '0;
    co_ang[2][0] = '0;
    co_ang[3][0] = '0;
    sb_co[0] = sb_sq[NR];
  end

  for (genvar k = 0; k < N; k++) begin : g_co
    for (genvar u = 0; u < 4; u++) begin : g_unit
      lik_cordic_cell #(.IDX(k)) u_cell (
        .clk   (clk),
        .en    (en),
        .cx_i  (co_x[u][k]),
        .cy_i  (co_y[u][k]),
        .ang_i (co_ang[u][k]),
        .cx_r  (co_x[u][k+1]),
        .cy_r  (co_y[u][k+1]),
        .ang_r (co_ang[u][k+1])
      );
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sb_co[k+1] <= '0;
      end else if (en) begin
        sb_co[k+1] <= sb_co[k];
      end
    end
  end

  // ---------------- combine angles ----------------
  logic signed [HW-1:0] base, tilt, bend, fwd, hip_nxt;
  logic signed [HW-1:0] hip_r, thigh_r, knee_r;
  lik_pkg::lik_side_t   sbc_r;
  logic signed [HW-1:0] pi_w;

  always_comb begin
    base = HW'(co_ang[0][N]);
    tilt = HW'(co_ang[1][N]);
    bend = HW'(co_ang[2][N]);
    fwd  = HW'(co_ang[3][N]);
    pi_w = HW'(lik_pkg::PI_Q30);
    if (!sb_co[N].leg[1]) begin
      hip_nxt = sb_co[N].yneg ? -(base + tilt) : pi_w - (base - tilt);
    end else begin
      hip_nxt = sb_co[N].ypos ? (base + tilt) : (base - tilt) - pi_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbc_r <= '0;
    end else if (en) begin
      sbc_r <= sb_co[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hip_r   <= hip_nxt;
      thigh_r <= fwd - bend;
      knee_r  <= bend <<< 1;
    end
  end

  // ---------------- rounding and output register ----------------
  localparam logic signed [HW-1:0] HALF = HW'(1) <<< (SH - 1);
  logic signed [HW-1:0] hip_rd, thigh_rd, knee_rd;
  logic [19:0]          hip_c, thigh_c;
  logic [18:0]          knee_c;

  always_comb begin
    hip_rd   = (hip_r + HALF) >>> SH;
    thigh_rd = (thigh_r + HALF) >>> SH;
    knee_rd  = (knee_r + HALF) >>> SH;
    hip_c    = sbc_r.unr ? '0 : hip_rd[19:0];
    thigh_c  = sbc_r.unr ? '0 : thigh_rd[19:0];
    knee_c   = sbc_r.unr ? '0 : knee_rd[18:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= sbc_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tuser <= {sbc_r.unr, sbc_r.leg};
      out_tdata <= {5'd0, knee_c, thigh_c, hip_c};
    end
  end

endmodule

`default_nettype wire

@@ rtl/lik_checker.sv @@
// ----------------------------------------------------------------------------
// lik_checker: port-level checks for leg_inverse_kinematics
// Watches the stream and stall behavior seen on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lik_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire [2:0]  out_tuser,
  input wire [63:0] out_tdata,
  input wire        out_tvalid,
  input wire        out_tready
);

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // no result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // out of reach gives zero angles
  a_unr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata == 64'd0)
    else $error("nonzero angles on unreachable target");

  // a waiting result blocks new requests
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken during output stall");

endmodule

bind leg_inverse_kinematics lik_checker u_lik_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

@@ tb/sv/leg_inverse_kinematics_test.sv @@
// ----------------------------------------------------------------------------
// leg_inverse_kinematics_test: self-checking bench for the leg IK pipeline
// Drives foot requests through the input stream under several length
// settings. A bit-true model predicts each result, and the result stream is
// checked against it in order. Both sides idle at random, and the receiver
// holds off for a long stretch once so that the pipeline backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module leg_inverse_kinematics_test;

  localparam int FRAC     = 16;
  localparam int STAGES   = 18;
  localparam int LATENCY  = 38 + STAGES;
  localparam int LIMIT    = 600000;
  localparam longint PI30 = 64'sd3373259426;

  typedef struct packed {
    logic [1:0]        leg;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } foot_req_t;

  typedef struct packed {
    logic [1:0]         leg;
    logic signed [19:0] hip;
    logic signed [19:0] thigh;
    logic [18:0]        knee;
    logic               unr;
  } joint_set_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [1:0]  in_tuser = '0;
  logic [55:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  out_tuser;
  logic [63:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  leg_inverse_kinematics dut (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  foot_req_t  foot_queue[$];
  joint_set_t angle_queue[$];
  foot_req_t  cur_req;
  longint     offset_len = 6554;
  longint     link_len = 13107;
  int         fail_count = 0;
  int         cycle_count = 0;
  bit         req_taken = 1'b0;
  bit         quiet = 1'b0;
  bit         hold_request = 1'b0;
  int         tx_idle = 0;
  int         rx_idle = 0;
  int         hold_cnt = 0;

  int atan_q30_tab[18] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                           33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                           524288, 262144, 131072, 65536, 32768, 16384, 8192};

  // floor square root, bit by bit
  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  // vectoring rotation, angle in 2^-30 rad, x operand non-negative
  function automatic longint vector_angle(longint y, longint x);
    longint cx, cy, dx, dy, ang;
    cx = x * 4096;
    cy = y * 4096;
    ang = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx = cx + dx;
        cy = cy - dy;
        ang = ang + atan_q30_tab[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        ang = ang - atan_q30_tab[i];
      end
    end
    return ang;
  endfunction

  // round half up from 2^-30 to 2^-FRAC rad
  function automatic longint angle_code(longint q30);
    return (q30 + (longint'(1) << (lik_pkg::ANG_BITS - FRAC - 1)))
           >>> (lik_pkg::ANG_BITS - FRAC);
  endfunction

  // expected joint angles for one foot request
  function automatic joint_set_t solve_leg(foot_req_t r);
    joint_set_t res;
    longint x, y, z, ax, ay, az, side, a2, red2, reach2, lim;
    longint r1, r2, h, base, tilt, bend, fwd, hip;
    x = r.x;
    y = r.y;
    z = r.z;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    res = '0;
    res.leg = r.leg;
    res.unr = 1'b1;
    side = ay * ay + az * az;
    a2 = offset_len * offset_len;
    if (side <= a2) return res;
    red2 = side - a2;
    reach2 = red2 + ax * ax;
    lim = 4 * link_len * link_len;
    if (reach2 > lim) return res;
    r1 = floor_sqrt(red2 << 24);
    r2 = floor_sqrt(reach2 << 24);
    h = floor_sqrt((lim - reach2) << 24);
    base = vector_angle(r1, offset_len * 4096);
    tilt = vector_angle(z * 4096, ay * 4096);
    bend = vector_angle(h, r2);
    fwd = vector_angle(x * 4096, r1);
    if (r.leg < 2) hip = (y < 0) ? -(base + tilt) : PI30 - (base - tilt);
    else hip = (y > 0) ? (base + tilt) : -(PI30 - (base - tilt));
    res.hip = 20'(angle_code(hip));
    res.thigh = 20'(angle_code(fwd - bend));
    res.knee = 19'(angle_code(2 * bend));
    res.unr = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    fail_count++;
  endtask

  task automatic add_foot(int leg, int x, int y, int z);
    foot_req_t r;
    r.leg = 2'(leg);
    r.x = 18'(x);
    r.y = 18'(y);
    r.z = 18'(z);
    foot_queue.push_back(r);
  endtask

  // one register write over the cfg port
  task automatic write_length(logic idx, int value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    if (idx == lik_pkg::REG_ABDUCTION) offset_len = value & 32'h1FFFF;
    else link_len = value & 32'h1FFFF;
  endtask

  task automatic drain_pipeline();
    wait (foot_queue.size() == 0 && !in_tvalid && angle_queue.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // accepted requests, predictions and result checks
  always @(posedge clk) begin
    joint_set_t want;
    cycle_count <= cycle_count + 1;
    req_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) angle_queue.push_back(solve_leg(cur_req));
    if (rst_n && out_tvalid && out_tready) begin
      if (angle_queue.size() == 0) begin
        report_mismatch("unexpected result count", 1, 0);
      end else begin
        want = angle_queue.pop_front();
        if (out_tuser[1:0] != want.leg) report_mismatch("leg_out", out_tuser[1:0], want.leg);
        if (out_tuser[2] != want.unr) report_mismatch("unreachable", out_tuser[2], want.unr);
        if (out_tdata[19:0] != want.hip)
          report_mismatch("hip_angle", $signed(out_tdata[19:0]), want.hip);
        if (out_tdata[39:20] != want.thigh)
          report_mismatch("thigh_angle", $signed(out_tdata[39:20]), want.thigh);
        if (out_tdata[58:40] != want.knee) report_mismatch("knee_angle", out_tdata[58:40], want.knee);
      end
    end
    if (cycle_count > LIMIT) begin
      $display("leg_inverse_kinematics_test NOT OK");
      $finish;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !req_taken)) begin
      if (tx_idle > 0) begin
        in_tvalid <= 1'b0;
        tx_idle <= tx_idle - 1;
      end else if (!quiet && foot_queue.size() != 0 && $urandom_range(0, 9) == 0) begin
        in_tvalid <= 1'b0;
        tx_idle <= $urandom_range(0, 16);
      end else if (foot_queue.size() != 0) begin
        cur_req = foot_queue.pop_front();
        in_tuser <= cur_req.leg;
        in_tdata <= {2'b00, cur_req.z, cur_req.y, cur_req.x};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_request && hold_cnt == 0 && !quiet) begin
      hold_request <= 1'b0;
      hold_cnt <= 300;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (rx_idle > 0) begin
      rx_idle <= rx_idle - 1;
      out_tready <= 1'b0;
    end else if (!quiet && rst_n && $urandom_range(0, 9) == 0) begin
      rx_idle <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
    end
  end

  // settings: reset values first, then extremes and a middle point
  int phase_offset[7] = '{6554, 0, 0, 131071, 0, 131071, 20000};
  int phase_link[7]   = '{13107, 1, 100, 131071, 131071, 1, 50000};

  initial begin
    int span;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, close-in, each leg and each side of y
    add_foot(0, 131071, 131071, 131071);
    add_foot(3, -131072, -131072, -131072);
    add_foot(1, 0, 0, 0);
    add_foot(2, 0, 6554, 0);
    add_foot(0, 0, -6554, 0);
    add_foot(0, 3000, -9000, -15000);
    add_foot(1, -3000, 9000, -15000);
    add_foot(2, 3000, 9000, -15000);
    add_foot(3, -3000, -9000, -15000);
    add_foot(0, 0, 0, -20000);
    add_foot(2, 0, 0, -20000);
    add_foot(1, 5000, 8000, 20000);
    add_foot(3, -131072, 10000, 0);
    add_foot(2, 100, 131071, -131072);

    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        drain_pipeline();
        write_length(lik_pkg::REG_ABDUCTION, phase_offset[p]);
        write_length(lik_pkg::REG_LINK, phase_link[p]);
      end
      if (p == 2) begin
        // reach exactly twice the link length
        add_foot(0, 0, 200, 0);
        add_foot(2, 0, -200, 0);
        add_foot(1, 0, 0, 200);
        add_foot(3, 120, 160, 0);
      end
      if (p == 6) quiet = 1'b1;
      span = 2 * phase_link[p] + phase_offset[p] + 3;
      if (span > 131071) span = 131071;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 9) < 7)
          add_foot($urandom_range(0, 3), $urandom_range(0, 2 * span) - span,
                   $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span);
        else
          add_foot($urandom_range(0, 3), $urandom_range(0, 262143) - 131072,
                   $urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072);
      end
      if (p == 3) hold_request = 1'b1;
    end

    drain_pipeline();
    if (fail_count == 0) begin
      $display("leg_inverse_kinematics_test OK");
    end else begin
      $display("leg_inverse_kinematics_test NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lik_pkg.sv
rtl/lik_sqrt_cell.sv
rtl/lik_cordic_cell.sv
rtl/leg_inverse_kinematics.sv
rtl/lik_checker.sv
tb/sv/leg_inverse_kinematics_test.sv
